>>> sv/mstt_pkg.sv
`timescale 1ns / 1ps

package mstt_pkg;

    // bank geometry
    localparam int SLOTS       = 8;
    localparam int COUNT_BITS  = 16;
    localparam int MAX_REPORTS = 8;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_REPORTS + 1);

    // field widths on the stream ports
    localparam int MODE_W    = 2;
    localparam int SLOT_W    = 3;
    localparam int PERIOD_W  = 16;
    localparam int PAYLOAD_W = 8;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 16;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK   = 2'd0,
        MODE_DEFINE = 2'd1,
        MODE_START  = 2'd2,
        MODE_STOP   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_FLUSH
    } t_state;

    // result of the shared decrement unit for one slot
    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic                  expired;
    } t_dec_res;

    function automatic logic [COUNT_BITS-1:0] fit_count(input logic [PERIOD_W-1:0] p);
        logic [COUNT_BITS+PERIOD_W-1:0] tmp;
        tmp = {{COUNT_BITS{1'b0}}, p};
        return tmp[COUNT_BITS-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] slot_to_idx(input logic [SLOT_W-1:0] s);
        logic [IDX_W+SLOT_W-1:0] tmp;
        tmp = {{IDX_W{1'b0}}, s};
        return tmp[IDX_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] idx_to_slot(input logic [IDX_W-1:0] i);
        logic [IDX_W+SLOT_W-1:0] tmp;
        tmp = {{SLOT_W{1'b0}}, i};
        return tmp[SLOT_W-1:0];
    endfunction

endpackage

>>> sv/mstt_ram.sv
`timescale 1ns / 1ps

module mstt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/mstt_dec.sv
`timescale 1ns / 1ps

module mstt_dec import mstt_pkg::*; (
    input  logic [COUNT_BITS-1:0] i_count,
    input  logic [COUNT_BITS-1:0] i_period,
    input  logic                  i_periodic,
    output t_dec_res              o_res
);

    logic [COUNT_BITS-1:0] dec_val;
    logic                  at_zero;

    // count wraps modulo 2^COUNT_BITS, so a zero count expires only after a full wrap
    assign dec_val = i_count - COUNT_BITS'(1);
    assign at_zero = (dec_val == '0);

    always_comb begin
        o_res.expired = at_zero;
        o_res.count   = (at_zero && i_periodic) ? i_period : dec_val;
    end

endmodule

>>> sv/multi_slot_tick_timer_bank.sv
`timescale 1ns / 1ps

// Bank of SLOTS countdown timers. Each input beat carries a mode in s_tuser:
// define loads a slot's period and count and leaves it disarmed, start stores
// a payload byte and arms the slot, stop disarms it; these are taken in the
// idle state and give no output. A tick is also taken in the idle state and
// walks the slots from 0 upward through one shared decrementer: each slot
// passes through ST_READ (the registered read of the slot memories) and
// ST_EXEC (decrement, test and write back), then ST_FLUSH sends the last
// report; the walk can hold in ST_EXEC and ST_FLUSH while the output stalls.
// Every armed slot whose count reaches zero gives one output beat (slot
// index and payload) in ascending slot order, tlast on the final beat of the
// tick, at most MAX_REPORTS beats per tick; a periodic slot then reloads its
// period, a one-shot slot disarms. A zero period or a zero count expires
// after 2^COUNT_BITS ticks. Slot state sits in small memories; per-slot
// written bits make a never-written count and a never-defined period read as
// zero, so no clearing pass is needed after reset. s_tready is high only
// while idle.
module multi_slot_tick_timer_bank import mstt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // slot[2:0], period[18:3], periodic[19],
                                             // payload[27:20], zero[31:28]
    input  logic [MODE_W-1:0]   i_s_tuser,   // mode[1:0]
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,   // fired_slot[2:0], fired_payload[10:3],
                                             // zero[15:11]
    output logic                o_m_tlast
);

    localparam int CFG_W = COUNT_BITS + 1;

    // input beat fields
    t_mode                 in_mode;
    logic [SLOT_W-1:0]     in_slot;
    logic [COUNT_BITS-1:0] in_period;
    logic                  in_periodic;
    logic [PAYLOAD_W-1:0]  in_payload;
    logic [IDX_W-1:0]      in_idx;
    logic                  in_slot_ok;
    logic                  in_acc;

    assign in_mode     = t_mode'(i_s_tuser);
    assign in_slot     = i_s_tdata[2:0];
    assign in_period   = fit_count(i_s_tdata[18:3]);
    assign in_periodic = i_s_tdata[19];
    assign in_payload  = i_s_tdata[27:20];
    assign in_idx      = slot_to_idx(in_slot);
    assign in_slot_ok  = (32'(in_slot) < SLOTS);
    assign in_acc      = i_s_tvalid && o_s_tready;

    // sequencer and report registers
    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_pend_v, n_pend_v;
    logic [SLOT_W-1:0]    r_pend_slot, n_pend_slot;
    logic [PAYLOAD_W-1:0] r_pend_pay, n_pend_pay;
    logic                 r_out_v, n_out_v;
    logic [SLOT_W-1:0]    r_out_slot, n_out_slot;
    logic [PAYLOAD_W-1:0] r_out_pay, n_out_pay;
    logic                 r_out_last, n_out_last;
    logic [SLOTS-1:0]     r_armed, n_armed;
    logic [SLOTS-1:0]     r_defined, n_defined;
    logic [SLOTS-1:0]     r_cnt_ok, n_cnt_ok;

    // slot memories
    logic                  cnt_we;
    logic [IDX_W-1:0]      cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [COUNT_BITS-1:0] cnt_rd;
    logic                  cfg_we;
    logic [CFG_W-1:0]      cfg_rd;
    logic                  pay_we;
    logic [PAYLOAD_W-1:0]  pay_rd;

    mstt_ram #(.WIDTH(COUNT_BITS), .DEPTH(SLOTS)) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (r_idx),
        .o_rdata (cnt_rd)
    );

    // periodic mark over reload period
    mstt_ram #(.WIDTH(CFG_W), .DEPTH(SLOTS)) u_cfg_ram (
        .i_clk   (i_clk),
        .i_we    (cfg_we),
        .i_waddr (in_idx),
        .i_wdata ({in_periodic, in_period}),
        .i_raddr (r_idx),
        .o_rdata (cfg_rd)
    );

    mstt_ram #(.WIDTH(PAYLOAD_W), .DEPTH(SLOTS)) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (in_idx),
        .i_wdata (in_payload),
        .i_raddr (r_idx),
        .o_rdata (pay_rd)
    );

    // a count never written reads as zero; a slot never defined reads as
    // period zero, one-shot
    logic                  cur_defined;
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] cur_period;
    logic                  cur_periodic;
    logic                  cur_armed;
    t_dec_res              dec_res;

    assign cur_defined  = r_defined[r_idx];
    assign cur_armed    = r_armed[r_idx];
    assign cur_count    = r_cnt_ok[r_idx] ? cnt_rd : '0;
    assign cur_period   = cur_defined ? cfg_rd[COUNT_BITS-1:0] : '0;
    assign cur_periodic = cur_defined && cfg_rd[COUNT_BITS];

    mstt_dec u_dec (
        .i_count    (cur_count),
        .i_period   (cur_period),
        .i_periodic (cur_periodic),
        .o_res      (dec_res)
    );

    logic out_free;
    logic fire;
    logic report;
    logic stall;

    assign out_free = !r_out_v || i_m_tready;
    assign fire     = cur_armed && dec_res.expired;
    assign report   = fire && (r_cnt < CNT_W'(MAX_REPORTS));
    // a new report pushes the held one out, which needs the output register
    assign stall    = report && r_pend_v && !out_free;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_pend_v    = r_pend_v;
        n_pend_slot = r_pend_slot;
        n_pend_pay  = r_pend_pay;
        n_out_v     = r_out_v;
        n_out_slot  = r_out_slot;
        n_out_pay   = r_out_pay;
        n_out_last  = r_out_last;
        n_armed     = r_armed;
        n_defined   = r_defined;
        n_cnt_ok    = r_cnt_ok;
        cnt_we      = 1'b0;
        cnt_waddr   = r_idx;
        cnt_wdata   = dec_res.count;
        cfg_we      = 1'b0;
        pay_we      = 1'b0;

        if (r_out_v && i_m_tready) begin
            n_out_v = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (in_mode)
                        MODE_TICK: begin
                            n_state = ST_READ;
                            n_idx   = '0;
                            n_cnt   = '0;
                        end
                        MODE_DEFINE: begin
                            if (in_slot_ok) begin
                                cnt_we            = 1'b1;
                                cnt_waddr         = in_idx;
                                cnt_wdata         = in_period;
                                cfg_we            = 1'b1;
                                n_defined[in_idx] = 1'b1;
                                n_cnt_ok[in_idx]  = 1'b1;
                                n_armed[in_idx]   = 1'b0;
                            end
                        end
                        MODE_START: begin
                            if (in_slot_ok) begin
                                pay_we          = 1'b1;
                                n_armed[in_idx] = 1'b1;
                            end
                        end
                        MODE_STOP: begin
                            if (in_slot_ok) begin
                                n_armed[in_idx] = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // memory read of the current slot is in flight
            ST_READ: begin
                n_state = ST_EXEC;
            end

            ST_EXEC: begin
                if (!stall) begin
                    if (cur_armed) begin
                        cnt_we          = 1'b1;
                        n_cnt_ok[r_idx] = 1'b1;
                    end
                    if (fire && !cur_periodic) begin
                        n_armed[r_idx] = 1'b0;
                    end
                    if (report) begin
                        if (r_pend_v) begin
                            n_out_v    = 1'b1;
                            n_out_slot = r_pend_slot;
                            n_out_pay  = r_pend_pay;
                            n_out_last = 1'b0;
                        end
                        n_pend_v    = 1'b1;
                        n_pend_slot = idx_to_slot(r_idx);
                        n_pend_pay  = pay_rd;
                        n_cnt       = r_cnt + CNT_W'(1);
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = ST_READ;
                    end
                end
            end

            // the held report is the final one of this tick
            ST_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out_slot = r_pend_slot;
                    n_out_pay  = r_pend_pay;
                    n_out_last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_cnt     <= '0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
            r_armed   <= '0;
            r_defined <= '0;
            r_cnt_ok  <= '0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_cnt     <= n_cnt;
            r_pend_v  <= n_pend_v;
            r_out_v   <= n_out_v;
            r_armed   <= n_armed;
            r_defined <= n_defined;
            r_cnt_ok  <= n_cnt_ok;
        end
    end

    // report payloads
    always_ff @(posedge i_clk) begin
        r_pend_slot <= n_pend_slot;
        r_pend_pay  <= n_pend_pay;
        r_out_slot  <= n_out_slot;
        r_out_pay   <= n_out_pay;
        r_out_last  <= n_out_last;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {{(M_DATA_W - SLOT_W - PAYLOAD_W){1'b0}}, r_out_pay, r_out_slot};
    assign o_m_tlast  = r_out_last;

    // nothing may be held over from one tick to the next
    a_idle_no_pending: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_v
    ) else $error("report still held while idle");

    a_report_cap: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_REPORTS)
    ) else $error("report count above limit");

    a_tick_starts_walk: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (in_mode == MODE_TICK)) |=> (r_state == ST_READ) && (r_idx == '0)
            && (r_cnt == '0)
    ) else $error("tick did not start a walk at slot zero");

    a_cmd_one_cycle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (in_mode != MODE_TICK)) |=> (r_state == ST_IDLE)
    ) else $error("slot command left the idle state");

endmodule

>>> test/tb_multi_slot_tick_timer_bank.sv
`timescale 1ns / 1ps

module tb_multi_slot_tick_timer_bank;
    import mstt_pkg::*;

    localparam int RANDOM_ITEMS   = 300;
    localparam int CALM_ITEMS     = 60;      // tail of the run without idling
    localparam int QUIET_LIMIT    = 5000;    // cycles with no beat on either side
    localparam int RX_HOLD_CYCLES = 200;
    localparam int TAIL_CYCLES    = 2 * SLOTS + 8;
    localparam int DIR_ROWS       = 26;

    typedef struct packed {
        t_mode                 mode;
        logic [SLOT_W-1:0]     slot;
        logic [PERIOD_W-1:0]   period;
        logic                  periodic;
        logic [PAYLOAD_W-1:0]  payload;
    } t_cmd;

    typedef struct packed {
        logic [SLOT_W-1:0]     slot;
        logic [PAYLOAD_W-1:0]  payload;
        logic                  last;
    } t_fire;

    // one stimulus row; where known is set the row's outcome is typed in:
    // either nothing, or a single expiry report carrying last
    typedef struct packed {
        t_mode                 mode;
        logic [SLOT_W-1:0]     slot;
        logic [PERIOD_W-1:0]   period;
        logic                  periodic;
        logic [PAYLOAD_W-1:0]  payload;
        logic                  known;
        logic                  fires;
        logic [SLOT_W-1:0]     f_slot;
        logic [PAYLOAD_W-1:0]  f_payload;
    } t_dir_row;

    t_dir_row dir_tab [DIR_ROWS] = '{
        // nothing armed after reset, stop of a disarmed slot
        '{MODE_TICK,   3'd0, 16'h0000, 1'b0, 8'h00, 1'b1, 1'b0, 3'd0, 8'h00},
        '{MODE_STOP,   3'd3, 16'h0000, 1'b0, 8'h00, 1'b1, 1'b0, 3'd0, 8'h00},
        // one-shot of period one fires once, then stays quiet
        '{MODE_DEFINE, 3'd0, 16'h0001, 1'b0, 8'h00, 1'b1, 1'b0, 3'd0, 8'h00},
        '{MODE_START,  3'd0, 16'h0000, 1'b0, 8'hFF, 1'b1, 1'b0, 3'd0, 8'h00},
        '{MODE_TICK,   3'd0, 16'h0000, 1'b0, 8'h00, 1'b1, 1'b1, 3'd0, 8'hFF},
        '{MODE_TICK,   3'd0, 16'h0000, 1'b0, 8'h00, 1'b1, 1'b0, 3'd0, 8'h00},
        // top slot, periodic of period one fires on every tick until stopped
        '{MODE_DEFINE, 3'd7, 16'h0001, 1'b1, 8'h00, 1'b1, 1'b0, 3'd0, 8'h00},
        '{MODE_START,  3'd7, 16'h0000, 1'b0, 8'h00, 1'b1, 1'b0, 3'd0, 8'h00},
        '{MODE_TICK,   3'd0, 16'h0000, 1'b0, 8'h00, 1'b1, 1'b1, 3'd7, 8'h00},
        '{MODE_TICK,   3'd0, 16'h0000, 1'b0, 8'h00, 1'b1, 1'b1, 3'd7, 8'h00},
        '{MODE_STOP,   3'd7, 16'h0000, 1'b0, 8'h00, 1'b1, 1'b0, 3'd0, 8'h00},
        '{MODE_TICK,   3'd0, 16'h0000, 1'b0, 8'h00, 1'b1, 1'b0, 3'd0, 8'h00},
        // largest period, zero period wrapping, start with unused fields high
        '{MODE_DEFINE, 3'd3, 16'hFFFF, 1'b1, 8'hFF, 1'b0, 1'b0, 3'd0, 8'h00},
        '{MODE_START,  3'd3, 16'hFFFF, 1'b1, 8'hAA, 1'b0, 1'b0, 3'd0, 8'h00},
        '{MODE_DEFINE, 3'd4, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00},
        '{MODE_START,  3'd4, 16'h0000, 1'b0, 8'h55, 1'b0, 1'b0, 3'd0, 8'h00},
        // restart of an armed slot replaces the payload, keeps the count
        '{MODE_DEFINE, 3'd1, 16'h0002, 1'b1, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00},
        '{MODE_START,  3'd1, 16'h0000, 1'b0, 8'h11, 1'b0, 1'b0, 3'd0, 8'h00},
        '{MODE_START,  3'd1, 16'h0000, 1'b0, 8'h22, 1'b0, 1'b0, 3'd0, 8'h00},
        '{MODE_TICK,   3'd7, 16'hFFFF, 1'b1, 8'hFF, 1'b0, 1'b0, 3'd0, 8'h00},
        '{MODE_TICK,   3'd0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00},
        // define of an armed slot disarms it, a later start keeps its count
        '{MODE_DEFINE, 3'd1, 16'h0001, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00},
        '{MODE_TICK,   3'd0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00},
        '{MODE_START,  3'd1, 16'h0000, 1'b0, 8'h5A, 1'b0, 1'b0, 3'd0, 8'h00},
        '{MODE_TICK,   3'd0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00},
        '{MODE_STOP,   3'd3, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00}
    };

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] i_s_tdata  = '0;
    logic [MODE_W-1:0]   i_s_tuser  = MODE_TICK;
    logic                i_m_tready = 1'b0;
    logic                o_s_tready;
    logic                o_m_tvalid;
    logic [M_DATA_W-1:0] o_m_tdata;
    logic                o_m_tlast;

    // own copy of the timer bank
    logic [COUNT_BITS-1:0] slot_count   [SLOTS];
    logic [COUNT_BITS-1:0] slot_reload  [SLOTS];
    logic                  slot_repeats [SLOTS];
    logic [PAYLOAD_W-1:0]  slot_payload [SLOTS];
    logic                  slot_armed   [SLOTS];

    t_fire pending_fires [$];

    int  n_errors     = 0;
    int  n_sent       = 0;
    int  n_ticks      = 0;
    int  n_results    = 0;
    int  most_fires   = 0;
    int  n_holds      = 0;
    int  n_drains     = 0;
    int  quiet_cycles = 0;
    int  tx_gap_pct   = 25;
    bit  calm         = 1'b0;
    bit  rx_hold_req  = 1'b0;

    multi_slot_tick_timer_bank i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // slot[2:0], period[18:3], periodic[19], payload[27:20]
        .i_s_tuser  (i_s_tuser),   // mode[1:0]
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // fired_slot[2:0], fired_payload[10:3]
        .o_m_tlast  (o_m_tlast)
    );

    initial begin : clock_gen
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        $display("%0t ns: mismatch on %s, got %0d, want %0d", $realtime, what, got, want);
    endtask

    // applies one command to the bank copy; a tick walks the slots upward and
    // queues one report per expiry, the final one of the tick marked last
    function automatic void advance_timers(input t_cmd c, input bit keep);
        t_fire burst [$];
        t_fire f;
        if (c.mode != MODE_TICK) begin
            if (int'(c.slot) >= SLOTS) return;
            case (c.mode)
                MODE_DEFINE: begin
                    slot_reload[c.slot]  = c.period;
                    slot_count[c.slot]   = c.period;
                    slot_repeats[c.slot] = c.periodic;
                    slot_armed[c.slot]   = 1'b0;
                end
                MODE_START: begin
                    slot_payload[c.slot] = c.payload;
                    slot_armed[c.slot]   = 1'b1;
                end
                default: begin
                    slot_armed[c.slot] = 1'b0;
                end
            endcase
            return;
        end
        n_ticks++;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_armed[i]) begin
                slot_count[i] = slot_count[i] - 1'b1;
                if (slot_count[i] == '0) begin
                    if (burst.size() < MAX_REPORTS) begin
                        f.slot    = SLOT_W'(i);
                        f.payload = slot_payload[i];
                        f.last    = 1'b0;
                        burst.push_back(f);
                    end
                    if (slot_repeats[i]) slot_count[i] = slot_reload[i];
                    else slot_armed[i] = 1'b0;
                end
            end
        end
        if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
        if (burst.size() > most_fires) most_fires = burst.size();
        if (keep) begin
            foreach (burst[k]) pending_fires.push_back(burst[k]);
        end
    endfunction

    // offers one beat, waits for it to be taken, then updates the bank copy;
    // a known row queues its typed outcome instead of the computed one
    task automatic push_command(input t_cmd c, input bit known = 1'b0, input bit fires = 1'b0,
                                input logic [SLOT_W-1:0] f_slot = '0,
                                input logic [PAYLOAD_W-1:0] f_payload = '0);
        t_fire f;
        if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= c.mode;
        i_s_tdata  <= {4'b0, c.payload, c.periodic, c.period, c.slot};
        do @(posedge i_clk); while (!o_s_tready);
        n_sent++;
        advance_timers(c, !known);
        if (known && fires) begin
            f.slot    = f_slot;
            f.payload = f_payload;
            f.last    = 1'b1;
            pending_fires.push_back(f);
        end
    endtask

    function automatic t_cmd make_cmd(input t_mode m, input logic [SLOT_W-1:0] s,
                                      input logic [PERIOD_W-1:0] p, input logic per,
                                      input logic [PAYLOAD_W-1:0] pay);
        t_cmd c;
        c.mode     = m;
        c.slot     = s;
        c.period   = p;
        c.periodic = per;
        c.payload  = pay;
        return c;
    endfunction

    // mostly short periods so slots expire often; now and then any value
    function automatic logic [PERIOD_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return PERIOD_W'($urandom_range(1, 6));
        if (r < 95) return PERIOD_W'($urandom_range(0, 65535));
        return '0;
    endfunction

    function automatic t_cmd any_tick();
        return make_cmd(MODE_TICK, SLOT_W'($urandom_range(0, 7)),
                        PERIOD_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                        PAYLOAD_W'($urandom_range(0, 255)));
    endfunction

    // every slot loaded with a one or two tick period, then a few ticks
    task automatic arm_every_slot();
        for (int s = 0; s < SLOTS; s++) begin
            push_command(make_cmd(MODE_DEFINE, SLOT_W'(s), PERIOD_W'($urandom_range(1, 2)),
                                  1'($urandom_range(0, 1)), PAYLOAD_W'($urandom_range(0, 255))));
            push_command(make_cmd(MODE_START, SLOT_W'(s), PERIOD_W'($urandom_range(0, 65535)),
                                  1'($urandom_range(0, 1)), PAYLOAD_W'($urandom_range(0, 255))));
        end
        repeat ($urandom_range(2, 4)) push_command(any_tick());
    endtask

    initial begin : stimulus
        t_cmd c;
        int   scen;
        int   s;
        for (int i = 0; i < SLOTS; i++) begin
            slot_count[i]   = '0;
            slot_reload[i]  = '0;
            slot_repeats[i] = 1'b0;
            slot_payload[i] = '0;
            slot_armed[i]   = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[r]) begin
            c = make_cmd(dir_tab[r].mode, dir_tab[r].slot, dir_tab[r].period,
                         dir_tab[r].periodic, dir_tab[r].payload);
            push_command(c, dir_tab[r].known, dir_tab[r].fires,
                         dir_tab[r].f_slot, dir_tab[r].f_payload);
        end

        scen = 0;
        while (n_sent < DIR_ROWS + RANDOM_ITEMS) begin
            scen++;
            tx_gap_pct = 25 * $urandom_range(0, 2);
            if (n_sent >= DIR_ROWS + RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            s = $urandom_range(0, SLOTS - 1);
            if (scen == 12) begin
                // receiver holds off while every slot is armed and ticks keep coming
                rx_hold_req = 1'b1;
                arm_every_slot();
            end else if (scen == 25 || $urandom_range(0, 19) == 0) begin
                // sender waits for every outstanding report before going on
                i_s_tvalid <= 1'b0;
                wait (pending_fires.size() == 0);
                @(posedge i_clk);
                n_drains++;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        push_command(make_cmd(MODE_DEFINE, SLOT_W'(s), pick_period(),
                                              1'($urandom_range(0, 1)),
                                              PAYLOAD_W'($urandom_range(0, 255))));
                        push_command(make_cmd(MODE_START, SLOT_W'(s),
                                              PERIOD_W'($urandom_range(0, 65535)),
                                              1'($urandom_range(0, 1)),
                                              PAYLOAD_W'($urandom_range(0, 255))));
                        repeat ($urandom_range(1, 5)) push_command(any_tick());
                    end
                    6: begin
                        repeat ($urandom_range(1, 4)) push_command(any_tick());
                    end
                    7: begin
                        // stray define, start or stop with random content
                        push_command(make_cmd(t_mode'($urandom_range(1, 3)), SLOT_W'(s),
                                              pick_period(), 1'($urandom_range(0, 1)),
                                              PAYLOAD_W'($urandom_range(0, 255))));
                    end
                    8: begin
                        arm_every_slot();
                    end
                    default: begin
                        // restart with a new payload, tick, stop, tick
                        push_command(make_cmd(MODE_START, SLOT_W'(s), '0, 1'b0,
                                              PAYLOAD_W'($urandom_range(0, 255))));
                        push_command(any_tick());
                        push_command(make_cmd(MODE_STOP, SLOT_W'(s),
                                              PERIOD_W'($urandom_range(0, 65535)), 1'b1,
                                              PAYLOAD_W'($urandom_range(0, 255))));
                        push_command(any_tick());
                    end
                endcase
            end
        end
        i_s_tvalid <= 1'b0;

        wait (pending_fires.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run covered %0d commands, %0d ticks and %0d expiry reports, up to %0d per tick",
                 n_sent, n_ticks, n_results, most_fires);
        $display("receiver hold-offs %0d, sender drain pauses %0d, mismatches %0d",
                 n_holds, n_drains, n_errors);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // output side: random stall bursts, one long hold-off on request,
    // always ready once the run goes calm
    initial begin : result_sink
        int gap_pct;
        int cyc;
        gap_pct = 20;
        cyc     = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 64 == 0) gap_pct = 20 * $urandom_range(0, 2);
            if (rx_hold_req) begin
                i_m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
                n_holds++;
                i_m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 99) < gap_pct) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // every output beat against the oldest queued expiry report
    always @(posedge i_clk) begin : result_check
        t_fire want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_results++;
            if (pending_fires.size() == 0) begin
                report_mismatch("unexpected report, fired_slot", o_m_tdata[SLOT_W-1:0], -1);
            end else begin
                want = pending_fires.pop_front();
                if (o_m_tdata[SLOT_W-1:0] !== want.slot)
                    report_mismatch("fired_slot", o_m_tdata[SLOT_W-1:0], want.slot);
                if (o_m_tdata[SLOT_W +: PAYLOAD_W] !== want.payload)
                    report_mismatch("fired_payload", o_m_tdata[SLOT_W +: PAYLOAD_W],
                                    want.payload);
                if (o_m_tlast !== want.last)
                    report_mismatch("last", o_m_tlast, want.last);
            end
        end
    end

    // ends the run when neither side has moved a beat for too long
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles, %0d reports outstanding",
                     quiet_cycles, pending_fires.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
